/* rtl/hdlc_pkg.sv */
`default_nettype none
package hdlc_pkg;

  localparam int MaxFrameDef = 2048;

  localparam logic [7:0]  FlagByte = 8'h7e;
  localparam logic [7:0]  EscByte  = 8'h7d;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] FcsInit  = 16'hffff;
  localparam logic [15:0] FcsGood  = 16'hf0b8;
  localparam logic [15:0] FcsPoly  = 16'h8408;

  localparam int LenW       = 11;
  localparam int InTdataW   = 8;
  localparam int OutTdataW  = 24;
  localparam int OutTuserW  = 2;
  localparam int QueueDepth = 2;
  localparam int QueueAw    = 1;

  typedef enum logic {
    KIND_DATA,
    KIND_FLAG
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic            byte_valid;
    logic [7:0]      data_byte;
    logic            frame_end;
    logic            frame_good;
    logic [LenW-1:0] frame_length;
  } result_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] c);
    logic [15:0] f;
    f = fcs ^ {8'h00, c};
    for (int k = 0; k < 8; k++) begin
      f = f[0] ? ((f >> 1) ^ FcsPoly) : (f >> 1);
    end
    return f;
  endfunction

endpackage
`default_nettype wire

/* rtl/hdlc_front.sv */
`default_nettype none
module hdlc_front
  import hdlc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InTdataW-1:0] s_axis_tdata,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output item_t                    item_o
);

  logic esc_q, esc_d;
  logic fire;

  assign s_axis_tready = !q_full_i;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    esc_d       = esc_q;
    push_o      = 1'b0;
    item_o.kind = KIND_DATA;
    item_o.data = s_axis_tdata;
    if (fire) begin
      if (s_axis_tdata == FlagByte) begin
        push_o      = 1'b1;
        item_o.kind = KIND_FLAG;
        esc_d       = 1'b0;
      end else if (esc_q) begin
        push_o      = 1'b1;
        item_o.data = s_axis_tdata ^ EscXor;
        esc_d       = 1'b0;
      end else if (s_axis_tdata == EscByte) begin
        esc_d = 1'b1;
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/hdlc_queue.sv */
`default_nettype none
module hdlc_queue
  import hdlc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       head_valid_o,
  output item_t      head_o
);

  item_t mem [QueueDepth];
  logic [QueueAw-1:0] wr_q, rd_q;
  logic [QueueAw:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o       = (cnt_q == (QueueAw+1)'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/hdlc_back.sv */
`default_nettype none
module hdlc_back
  import hdlc_pkg::*;
#(
  parameter int MaxFrame = MaxFrameDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  wire item_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output result_t    out_o
);

  localparam int CntW = $clog2(MaxFrame + 1);

  logic [15:0]     fcs_q, fcs_d, fcs_new;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      h0_q, h0_d, h1_q, h1_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, res;
  logic            has_res;

  assign pop_o       = head_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign fcs_new     = fcs_update(fcs_q, head_i.data);
  assign cnt_inc     = cnt_q + 1'b1;

  always_comb begin
    fcs_d   = fcs_q;
    cnt_d   = cnt_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    res     = '0;
    has_res = 1'b0;
    if (pop_o) begin
      if (head_i.kind == KIND_FLAG) begin
        has_res       = 1'b1;
        res.frame_end = 1'b1;
        if (cnt_q >= CntW'(2)) begin
          res.frame_good   = (fcs_q == FcsGood);
          res.frame_length = LenW'(cnt_q - CntW'(2));
        end
        fcs_d = FcsInit;
        cnt_d = '0;
      end else begin
        if (cnt_q >= CntW'(2)) begin
          has_res        = 1'b1;
          res.byte_valid = 1'b1;
          res.data_byte  = h0_q;
        end
        h0_d = h1_q;
        h1_d = head_i.data;
        if (cnt_inc >= CntW'(MaxFrame)) begin
          has_res          = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_good   = (fcs_new == FcsGood);
          res.frame_length = LenW'(cnt_inc - CntW'(2));
          fcs_d            = FcsInit;
          cnt_d            = '0;
        end else begin
          fcs_d = fcs_new;
          cnt_d = cnt_inc;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || out_ready_i) begin
      out_valid_d = pop_o && has_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_q       <= FcsInit;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fcs_q       <= fcs_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h0_q <= h0_d;
    h1_q <= h1_d;
    if (pop_o && has_res) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

/* rtl/hdlc_async_frame_decoder.sv */
// Path: a line byte accepted at the input is written into the two-entry queue, and its
// result beat is then registered in the output register before it appears on the output.
// Throughput: one line byte per cycle while the queue is not full; destuffing and the
// byte-wide FCS-16 update are combinational logic, and escape bytes give no beat.
// Stalls: s_axis_tready drops while the two-entry queue is full, which an output stall
// causes; input resumes in the cycle after the stall lifts.
// Reset: escape flag cleared, FCS set to 0xffff, byte count zero, queue and
// output register empty; the two held data bytes are not reset.
`default_nettype none
module hdlc_async_frame_decoder
  import hdlc_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,   // data_byte[7:0], frame_length[18:8], zero
  output logic [OutTuserW-1:0]      m_axis_tuser,   // byte_valid[0], frame_good[1]
  output logic                      m_axis_tlast    // frame_end
);

  logic    q_full, push, pop, head_valid;
  item_t   item, head;
  result_t res;

  hdlc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (item)
  );

  hdlc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  hdlc_back #(
    .MaxFrame (MAX_FRAME)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {(OutTdataW - 8 - LenW)'(0), res.frame_length, res.data_byte};
  assign m_axis_tuser = {res.frame_good, res.byte_valid};
  assign m_axis_tlast = res.frame_end;

endmodule
`default_nettype wire

/* rtl/hdlc_chk.sv */
`default_nettype none
module hdlc_chk
  import hdlc_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OutTdataW-1:0] m_axis_tdata,
  input wire logic [OutTuserW-1:0] m_axis_tuser,
  input wire logic                 m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
    else $error("beat carries neither data nor frame end");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("data byte not zero without byte_valid");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[1] && m_axis_tdata[18:8] == 11'd0)
    else $error("frame status set outside frame end");

endmodule

bind hdlc_async_frame_decoder hdlc_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
